// File: src/clw_pkg.sv
// shared types, constants and codes of the claim ledger
package clw_pkg;

  localparam int OWN_N    = 64;
  localparam int ITEM_N   = 256;
  localparam int OWN_IW   = $clog2(OWN_N);
  localparam int ITEM_IW  = $clog2(ITEM_N);
  localparam int OWN_CW   = $clog2(OWN_N + 1);
  localparam int ITEM_CW  = $clog2(ITEM_N + 1);
  localparam int LEASE_W  = 24;
  localparam int TIME_W   = 32;
  localparam logic [LEASE_W-1:0] MIN_LEASE   = 24'd256;
  localparam logic [LEASE_W-1:0] LEASE_RESET = 24'd768;

  typedef enum logic [2:0] {
    OP_CLAIM_OWNER   = 3'd0,
    OP_CLAIM_ITEM    = 3'd1,
    OP_RELEASE       = 3'd2,
    OP_RELEASE_ITEMS = 3'd3,
    OP_SWEEP         = 3'd4,
    OP_QUERY_OWNER   = 3'd5,
    OP_QUERY_ITEM    = 3'd6
  } op_e;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [63:0]       owner_id;
    logic signed [63:0]       item_id;
    logic [TIME_W-1:0]        now_time;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [6:0] owners_removed;
    logic [8:0] items_changed;
    logic [6:0] owner_total;
    logic [8:0] item_total;
  } out_t;

  // token passed from cell to cell along the owner row
  typedef struct packed {
    logic              act;
    logic              found;
    logic              free_ok;
    logic [OWN_IW-1:0] free_idx;
    logic [OWN_CW-1:0] removed;
    logic [OWN_CW-1:0] total;
  } own_tok_t;

  // token passed from cell to cell along the item row
  typedef struct packed {
    logic               act;
    logic               found;
    logic               free_ok;
    logic [ITEM_IW-1:0] free_idx;
    logic [ITEM_CW-1:0] removed;
    logic [ITEM_CW-1:0] total;
  } item_tok_t;

  typedef struct packed {
    logic               en;
    logic [OWN_IW-1:0]  idx;
    logic signed [63:0] key;
    logic [TIME_W-1:0]  expiry;
  } own_wr_t;

  typedef struct packed {
    logic               en;
    logic [ITEM_IW-1:0] idx;
    logic signed [63:0] key;
    logic [TIME_W-1:0]  expiry;
    logic signed [63:0] owner;
  } item_wr_t;

endpackage

// File: src/clw_own_cell.sv
// one owner claim entry with its stage of the passing token
module clw_own_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  clw_pkg::in_t              req_i,
  input  logic [clw_pkg::OWN_IW-1:0] idx_i,
  input  clw_pkg::own_tok_t         tok_i,
  input  clw_pkg::own_wr_t          wr_i,
  output clw_pkg::own_tok_t         tok_o
);
  import clw_pkg::*;

  logic               valid_q, valid_d;
  logic signed [63:0] key_q;
  logic [TIME_W-1:0]  exp_q;
  logic               match, expired, wr_hit;
  own_tok_t           tok_d, tok_q;

  assign match   = valid_q && (key_q == req_i.owner_id);
  assign expired = valid_q && (exp_q <= req_i.now_time);
  assign wr_hit  = wr_i.en && (wr_i.idx == idx_i);

  // per-entry work as the token passes
  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    if (tok_i.act) begin
      case (op_e'(req_i.operation))
        OP_CLAIM_OWNER: begin
          tok_d.found = tok_i.found | match;
          if (!valid_q && !tok_i.free_ok) begin
            tok_d.free_ok  = 1'b1;
            tok_d.free_idx = idx_i;
          end
        end
        OP_RELEASE: begin
          if (match) begin
            valid_d       = 1'b0;
            tok_d.removed = tok_i.removed + OWN_CW'(1);
          end
        end
        OP_SWEEP: begin
          if (expired) begin
            valid_d       = 1'b0;
            tok_d.removed = tok_i.removed + OWN_CW'(1);
          end
        end
        OP_QUERY_OWNER: tok_d.found = tok_i.found | match;
        default: ;
      endcase
      tok_d.total = tok_i.total + OWN_CW'(valid_d);
    end
    if (wr_hit) begin
      valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      key_q <= wr_i.key;
      exp_q <= wr_i.expiry;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: src/clw_item_cell.sv
// one item claim entry with its stage of the passing token
module clw_item_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  clw_pkg::in_t               req_i,
  input  logic [clw_pkg::ITEM_IW-1:0] idx_i,
  input  clw_pkg::item_tok_t         tok_i,
  input  clw_pkg::item_wr_t          wr_i,
  output clw_pkg::item_tok_t         tok_o
);
  import clw_pkg::*;

  logic               valid_q, valid_d;
  logic signed [63:0] key_q;
  logic signed [63:0] owner_q;
  logic [TIME_W-1:0]  exp_q;
  logic               match, owned, expired, wr_hit;
  item_tok_t          tok_d, tok_q;

  assign match   = valid_q && (key_q == req_i.item_id);
  assign owned   = valid_q && (owner_q == req_i.owner_id);
  assign expired = valid_q && (exp_q <= req_i.now_time);
  assign wr_hit  = wr_i.en && (wr_i.idx == idx_i);

  // per-entry work as the token passes
  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    if (tok_i.act) begin
      case (op_e'(req_i.operation))
        OP_CLAIM_ITEM: begin
          tok_d.found = tok_i.found | match;
          if (!valid_q && !tok_i.free_ok) begin
            tok_d.free_ok  = 1'b1;
            tok_d.free_idx = idx_i;
          end
        end
        OP_RELEASE, OP_RELEASE_ITEMS: begin
          if (owned) begin
            valid_d       = 1'b0;
            tok_d.removed = tok_i.removed + ITEM_CW'(1);
          end
        end
        OP_SWEEP: begin
          if (expired) begin
            valid_d       = 1'b0;
            tok_d.removed = tok_i.removed + ITEM_CW'(1);
          end
        end
        OP_QUERY_ITEM: tok_d.found = tok_i.found | match;
        default: ;
      endcase
      tok_d.total = tok_i.total + ITEM_CW'(valid_d);
    end
    if (wr_hit) begin
      valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      key_q   <= wr_i.key;
      exp_q   <= wr_i.expiry;
      owner_q <= wr_i.owner;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: src/claim_ledger_with_expiry.sv
// claim ledger top: owner and item cell rows, sequencer and result register
// a request waits in the sequencer while a token walks one cell per cycle down each row;
//   the result is registered once both tokens have arrived, and no new request is
//   taken until that result has left the result register
// reset: all entries free, lease length 768, no result pending
module claim_ledger_with_expiry (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  clw_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output clw_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [clw_pkg::LEASE_W-1:0]     cfg_data_i
);
  import clw_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_e;

  state_e              state_q;
  in_t                 req_q;
  logic                start_q;
  logic [LEASE_W-1:0]  lease_q;
  logic                own_done_q, item_done_q;
  own_tok_t            own_res_q;
  item_tok_t           item_res_q;
  own_wr_t             own_wr_q;
  item_wr_t            item_wr_q;
  out_t                out_q;
  logic                out_valid_q;

  own_tok_t            own_tok  [OWN_N+1];
  item_tok_t           item_tok [ITEM_N+1];
  own_tok_t            own_fin;
  item_tok_t           item_fin;
  logic                finish;
  logic [LEASE_W-1:0]  lease_eff;
  logic [TIME_W:0]     exp_sum;
  logic [TIME_W-1:0]   expiry;
  out_t                res;
  logic                own_ins, item_ins;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // token injected at the head of each row
  always_comb begin
    own_tok[0]      = '0;
    own_tok[0].act  = start_q;
    item_tok[0]     = '0;
    item_tok[0].act = start_q;
  end

  // owner row
  for (genvar i = 0; i < OWN_N; i++) begin : g_own
    clw_own_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .idx_i  (OWN_IW'(i)),
      .tok_i  (own_tok[i]),
      .wr_i   (own_wr_q),
      .tok_o  (own_tok[i+1])
    );
  end

  // item row
  for (genvar i = 0; i < ITEM_N; i++) begin : g_item
    clw_item_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .idx_i  (ITEM_IW'(i)),
      .tok_i  (item_tok[i]),
      .wr_i   (item_wr_q),
      .tok_o  (item_tok[i+1])
    );
  end

  // saturating expiry
  assign lease_eff = (lease_q < MIN_LEASE) ? MIN_LEASE : lease_q;
  assign exp_sum   = {1'b0, req_q.now_time} + (TIME_W+1)'(lease_eff);
  assign expiry    = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  // both row tokens arrived
  assign own_fin  = own_tok[OWN_N].act ? own_tok[OWN_N] : own_res_q;
  assign item_fin = item_tok[ITEM_N].act ? item_tok[ITEM_N] : item_res_q;
  assign finish   = (state_q == S_RUN) && (own_done_q || own_tok[OWN_N].act)
                    && (item_done_q || item_tok[ITEM_N].act);

  // result of the request
  always_comb begin
    res                = '0;
    res.status         = ST_MISS;
    res.owner_total    = 7'(own_fin.total);
    res.item_total     = 9'(item_fin.total);
    own_ins            = 1'b0;
    item_ins           = 1'b0;
    case (op_e'(req_q.operation))
      OP_CLAIM_OWNER: begin
        if (own_fin.found) begin
          res.status = ST_MISS;
        end else if (!own_fin.free_ok) begin
          res.status = ST_FULL;
        end else begin
          res.status      = ST_DONE;
          own_ins         = 1'b1;
          res.owner_total = 7'(own_fin.total + OWN_CW'(1));
        end
      end
      OP_CLAIM_ITEM: begin
        if (item_fin.found) begin
          res.status = ST_MISS;
        end else if (!item_fin.free_ok) begin
          res.status = ST_FULL;
        end else begin
          res.status        = ST_DONE;
          item_ins          = 1'b1;
          res.items_changed = 9'd1;
          res.item_total    = 9'(item_fin.total + ITEM_CW'(1));
        end
      end
      OP_RELEASE, OP_SWEEP: begin
        res.owners_removed = 7'(own_fin.removed);
        res.items_changed  = 9'(item_fin.removed);
        res.status = ((own_fin.removed != '0) || (item_fin.removed != '0)) ? ST_DONE : ST_MISS;
      end
      OP_RELEASE_ITEMS: begin
        res.items_changed = 9'(item_fin.removed);
        res.status        = (item_fin.removed != '0) ? ST_DONE : ST_MISS;
      end
      OP_QUERY_OWNER: begin
        res.hit    = own_fin.found;
        res.status = own_fin.found ? ST_DONE : ST_MISS;
      end
      OP_QUERY_ITEM: begin
        res.hit    = item_fin.found;
        res.status = item_fin.found ? ST_DONE : ST_MISS;
      end
      default: ;
    endcase
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_data_i;
    end
  end

  // sequencer, commit writes and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      lease_q     <= LEASE_RESET;
      own_done_q  <= 1'b0;
      item_done_q <= 1'b0;
      own_res_q   <= '0;
      item_res_q  <= '0;
      own_wr_q    <= '0;
      item_wr_q   <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q      <= 1'b0;
      own_wr_q.en  <= 1'b0;
      item_wr_q.en <= 1'b0;
      if (cfg_valid_i) begin
        lease_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q     <= S_RUN;
            start_q     <= 1'b1;
            own_done_q  <= 1'b0;
            item_done_q <= 1'b0;
          end
        end
        S_RUN: begin
          if (own_tok[OWN_N].act) begin
            own_done_q <= 1'b1;
            own_res_q  <= own_tok[OWN_N];
          end
          if (item_tok[ITEM_N].act) begin
            item_done_q <= 1'b1;
            item_res_q  <= item_tok[ITEM_N];
          end
          if (finish) begin
            state_q          <= S_OUT;
            out_q            <= res;
            out_valid_q      <= 1'b1;
            own_wr_q.en      <= own_ins;
            own_wr_q.idx     <= own_fin.free_idx;
            own_wr_q.key     <= req_q.owner_id;
            own_wr_q.expiry  <= expiry;
            item_wr_q.en     <= item_ins;
            item_wr_q.idx    <= item_fin.free_idx;
            item_wr_q.key    <= req_q.item_id;
            item_wr_q.expiry <= expiry;
            item_wr_q.owner  <= req_q.owner_id;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: dv/tb_claim_ledger_with_expiry.sv
// testbench for the claim ledger: predictor scoreboard, request driver and result checker
`timescale 1ns / 100ps

module tb_claim_ledger_with_expiry;
  import clw_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  // ledger predictor and queue of expected responses
  class claim_book;
    bit [23:0]   lease;
    bit          own_v[OWN_N];
    bit [63:0]   own_k[OWN_N];
    bit [31:0]   own_e[OWN_N];
    bit          itm_v[ITEM_N];
    bit [63:0]   itm_k[ITEM_N];
    bit [31:0]   itm_e[ITEM_N];
    bit [63:0]   itm_o[ITEM_N];
    out_t        due_q[$];
    int          errors;

    function new();
      lease = LEASE_RESET;
      errors = 0;
      foreach (own_v[i]) own_v[i] = 0;
      foreach (itm_v[i]) itm_v[i] = 0;
    endfunction

    function bit [31:0] expiry_at(bit [31:0] now);
      bit [32:0] sum;
      bit [23:0] eff;
      eff = (lease < MIN_LEASE) ? MIN_LEASE : lease;
      sum = {1'b0, now} + eff;
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function int owner_slot(bit [63:0] key);
      foreach (own_v[i]) if (own_v[i] && own_k[i] == key) return i;
      return -1;
    endfunction

    function int item_slot(bit [63:0] key);
      foreach (itm_v[i]) if (itm_v[i] && itm_k[i] == key) return i;
      return -1;
    endfunction

    function int drop_items_of(bit [63:0] owner);
      int n;
      n = 0;
      foreach (itm_v[i]) if (itm_v[i] && itm_o[i] == owner) begin
        itm_v[i] = 0;
        n++;
      end
      return n;
    endfunction

    // apply one accepted request to the ledger and queue its response
    function void note_request(in_t rq);
      out_t r;
      int slot, n_own, n_itm;
      r = '0;
      r.status = ST_MISS;
      n_own = 0;
      n_itm = 0;
      case (rq.operation)
        OP_CLAIM_OWNER: begin
          if (owner_slot(rq.owner_id) < 0) begin
            slot = -1;
            foreach (own_v[i]) if (!own_v[i] && slot < 0) slot = i;
            if (slot < 0) r.status = ST_FULL;
            else begin
              own_v[slot] = 1;
              own_k[slot] = rq.owner_id;
              own_e[slot] = expiry_at(rq.now_time);
              r.status = ST_DONE;
            end
          end
        end
        OP_CLAIM_ITEM: begin
          if (item_slot(rq.item_id) < 0) begin
            slot = -1;
            foreach (itm_v[i]) if (!itm_v[i] && slot < 0) slot = i;
            if (slot < 0) r.status = ST_FULL;
            else begin
              itm_v[slot] = 1;
              itm_k[slot] = rq.item_id;
              itm_e[slot] = expiry_at(rq.now_time);
              itm_o[slot] = rq.owner_id;
              n_itm = 1;
              r.status = ST_DONE;
            end
          end
        end
        OP_RELEASE: begin
          slot = owner_slot(rq.owner_id);
          if (slot >= 0) begin
            own_v[slot] = 0;
            n_own = 1;
          end
          n_itm = drop_items_of(rq.owner_id);
          r.status = (n_own || n_itm) ? ST_DONE : ST_MISS;
        end
        OP_RELEASE_ITEMS: begin
          n_itm = drop_items_of(rq.owner_id);
          r.status = n_itm ? ST_DONE : ST_MISS;
        end
        OP_SWEEP: begin
          foreach (own_v[i]) if (own_v[i] && own_e[i] <= rq.now_time) begin
            own_v[i] = 0;
            n_own++;
          end
          foreach (itm_v[i]) if (itm_v[i] && itm_e[i] <= rq.now_time) begin
            itm_v[i] = 0;
            n_itm++;
          end
          r.status = (n_own || n_itm) ? ST_DONE : ST_MISS;
        end
        OP_QUERY_OWNER: begin
          r.hit = owner_slot(rq.owner_id) >= 0;
          r.status = r.hit ? ST_DONE : ST_MISS;
        end
        OP_QUERY_ITEM: begin
          r.hit = item_slot(rq.item_id) >= 0;
          r.status = r.hit ? ST_DONE : ST_MISS;
        end
        default: r.status = ST_MISS;
      endcase
      r.owners_removed = n_own[6:0];
      r.items_changed = n_itm[8:0];
      foreach (own_v[i]) r.owner_total += own_v[i];
      foreach (itm_v[i]) r.item_total += itm_v[i];
      due_q = {due_q, r};
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // compare one response with the oldest expectation
    task check_result(out_t got);
      out_t want;
      if (due_q.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
        return;
      end
      want = due_q.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.owners_removed != want.owners_removed)
        report_mismatch("owners_removed", got.owners_removed, want.owners_removed);
      if (got.items_changed != want.items_changed)
        report_mismatch("items_changed", got.items_changed, want.items_changed);
      if (got.owner_total != want.owner_total)
        report_mismatch("owner_total", got.owner_total, want.owner_total);
      if (got.item_total != want.item_total)
        report_mismatch("item_total", got.item_total, want.item_total);
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LEASE_W-1:0] cfg_data_i = '0;

  claim_book book = new();
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        rx_hold_req = 0;
  int        cycles = 0;
  bit [31:0] t_now = 0;
  bit [63:0] owner_pool[80];
  bit [63:0] item_pool[320];

  claim_ledger_with_expiry DUT (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk_i) begin
    int hold;
    if (rx_hold_req > 0) begin
      hold = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold > 0) begin
      hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // request and response monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) book.note_request(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) book.check_result(out_data_o);
  end

  task automatic send_request(in_t rq);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_lease(bit [23:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    book.lease = value;
  endtask

  function automatic in_t make_request(op_e op, bit [63:0] own, bit [63:0] itm,
                                       bit [31:0] now);
    in_t rq;
    rq.operation = op;
    rq.owner_id = own;
    rq.item_id = itm;
    rq.now_time = now;
    return rq;
  endfunction

  // weighted random request over small id pools so claims collide and tables fill
  function automatic in_t random_request();
    int w;
    op_e op;
    bit [63:0] own, itm;
    w = $urandom_range(99);
    if (w < 20) op = OP_CLAIM_OWNER;
    else if (w < 55) op = OP_CLAIM_ITEM;
    else if (w < 60) op = OP_RELEASE;
    else if (w < 65) op = OP_RELEASE_ITEMS;
    else if (w < 70) op = OP_SWEEP;
    else if (w < 85) op = OP_QUERY_OWNER;
    else op = OP_QUERY_ITEM;
    own = owner_pool[$urandom_range(79)];
    itm = item_pool[$urandom_range(319)];
    if ($urandom_range(99) < 8) own = {$urandom, $urandom};
    if ($urandom_range(99) < 8) itm = {$urandom, $urandom};
    w = $urandom_range(99);
    if (w < 3) t_now = $urandom;
    else if (w < 5) t_now = 32'hFFFF_FFFF - $urandom_range(2000);
    else t_now = t_now + $urandom_range(0, 6);
    return make_request(op, own, itm, t_now);
  endfunction

  task automatic random_phase(int count, bit hold_off, bit pause);
    for (int i = 0; i < count; i++) begin
      if (hold_off && i == count / 3) rx_hold_req = 3000;
      if (pause && i == count / 2) drain();
      send_request(random_request());
    end
  endtask

  // main sequence
  initial begin
    bit [63:0] id_lo, id_hi;
    id_lo = 64'h8000_0000_0000_0000;
    id_hi = 64'h7FFF_FFFF_FFFF_FFFF;
    foreach (owner_pool[i]) owner_pool[i] = {$urandom, $urandom};
    foreach (item_pool[i]) item_pool[i] = {$urandom, $urandom};
    owner_pool[0] = id_lo;
    owner_pool[1] = id_hi;
    owner_pool[2] = 0;
    owner_pool[3] = '1;
    item_pool[0] = id_lo;
    item_pool[1] = id_hi;
    item_pool[2] = 0;
    item_pool[3] = '1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misses, duplicates, saturation, releases, expiry boundary
    send_request(make_request(OP_QUERY_OWNER, id_lo, 0, 0));
    send_request(make_request(OP_CLAIM_OWNER, id_lo, 0, 0));
    send_request(make_request(OP_CLAIM_OWNER, id_lo, 0, 500));
    send_request(make_request(OP_QUERY_OWNER, id_lo, 0, 0));
    send_request(make_request(OP_CLAIM_ITEM, id_hi, id_lo, 32'hFFFF_FFF0));
    send_request(make_request(OP_CLAIM_ITEM, id_hi, id_lo, 0));
    send_request(make_request(OP_CLAIM_ITEM, id_lo, id_hi, 10));
    send_request(make_request(OP_QUERY_ITEM, 0, id_hi, 0));
    send_request(make_request(OP_QUERY_ITEM, 0, 0, 0));
    send_request(make_request(OP_SWEEP, 0, 0, 32'hFFFF_FFFE));
    send_request(make_request(OP_RELEASE_ITEMS, id_hi, 0, 0));
    send_request(make_request(OP_RELEASE_ITEMS, id_hi, 0, 0));
    send_request(make_request(OP_RELEASE, id_lo, 0, 0));
    send_request(make_request(OP_RELEASE, id_lo, 0, 0));
    send_request(make_request(OP_SWEEP, 0, 0, 0));
    send_request(make_request(OP_CLAIM_OWNER, '1, 0, 0));
    send_request(make_request(OP_SWEEP, 0, 0, 767));
    send_request(make_request(OP_SWEEP, 0, 0, 768));
    send_request(make_request(OP_CLAIM_ITEM, 0, '1, 32'hFFFF_FFFF));
    send_request(make_request(OP_SWEEP, 0, 0, 32'hFFFF_FFFF));

    write_lease(24'd256);
    tx_idle_pct = 12;
    rx_idle_pct = 57;
    random_phase(530, 1'b1, 1'b0);

    write_lease(24'hFF_FFFF);
    tx_idle_pct = 57;
    rx_idle_pct = 12;
    random_phase(530, 1'b0, 1'b1);

    write_lease(24'($urandom_range(256, 24'hFF_FFFF)));
    write_lease(LEASE_RESET);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(540, 1'b0, 1'b0);

    drain();
    repeat (300) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
